// ===== rtl/core/packet_deframer_sum16_assert.svh =====
// Assertion macros used by the deframer RTL (pds_replay).
`ifndef PACKET_DEFRAMER_SUM16_ASSERT_SVH
`define PACKET_DEFRAMER_SUM16_ASSERT_SVH

`ifndef SYNTHESIS

// Check that expr holds at every clock edge outside reset.
`define PDS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expr");

// Check that post holds in the cycle after pre.
`define PDS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: pre then post");

`else

`define PDS_ASSERT(lbl, expr)
`define PDS_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/core/pds_pkg.sv =====
`timescale 1ns / 1ps
package pds_pkg;

    localparam int HDR_TRL_BYTES = 6;
    localparam int ID_POS = 2;
    localparam int SIZE_POS = 3;
    localparam int ADDR_BITS = 6;
    localparam int TOTAL_BITS = 9;
    localparam logic [7:0] SYNC_MARK_RESET = 8'hFF;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_ABORT = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic {
        CMD_WRITE,
        CMD_LAST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [ADDR_BITS-1:0]  addr;
        logic [7:0]            data;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } replay_state_t;

endpackage

// ===== rtl/core/packet_deframer_sum16.sv =====
`timescale 1ns / 1ps
// Receive deframer for byte-serial packets (mark, mark, id, size, payload,
// checksum high, checksum low) checked with a 16-bit additive sum. The parser
// takes one received byte or abort per cycle whenever its two-entry command
// queue has room; it never needs to read the packet store. A packet that
// passes its checksum is replayed from id through checksum low; for each
// byte the replayer does a registered read of the single packet memory,
// then shows the byte on the output register until the output accepts it.
// While a replay runs, the queue holds up to two further stored bytes;
// marks, aborts and dropped bytes take no slot, and once the queue is full
// every input item stalls until the replay ends. The packet memory needs no
// clearing after reset. sync_mark resets to 0xFF and may be written only
// while the block is idle.
module packet_deframer_sum16
    import pds_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;

    pds_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .cmd_valid(f_valid),
        .cmd_ready(f_ready),
        .cmd      (f_cmd)
    );

    pds_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_cmd  (f_cmd),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cmd   (q_cmd)
    );

    pds_replay #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_replay (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(q_valid),
        .cmd_ready(q_ready),
        .cmd      (q_cmd),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

endmodule

// ===== rtl/core/pds_front.sv =====
`timescale 1ns / 1ps
module pds_front
    import pds_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [7:0] cfg_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    localparam int LW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    sync_mark_reg;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] len_reg, len_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    hi_reg, hi_next;
    logic          in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = cmd_ready;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mark_reg <= SYNC_MARK_RESET;
            pos_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                sync_mark_reg <= cfg_data;
            end
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        hi_reg  <= hi_next;
    end

    always_comb
    begin
        logic [TOTAL_BITS-1:0] total;
        logic [LW-1:0]         len_eff;
        logic [LW:0]           pos_ext;
        logic [LW:0]           len_ext;
        logic                  oversize;
        logic                  match;

        total    = TOTAL_BITS'(in_item.rx_byte) + TOTAL_BITS'(HDR_TRL_BYTES);
        match    = (in_item.rx_byte == sync_mark_reg);
        pos_ext  = (LW+1)'(pos_reg);
        len_eff  = len_reg;
        oversize = 1'b0;
        pos_next = pos_reg;
        len_next = len_reg;
        sum_next = sum_reg;
        hi_next  = hi_reg;
        cmd_valid = 1'b0;
        cmd.kind  = CMD_WRITE;
        cmd.addr  = ADDR_BITS'(pos_reg);
        cmd.data  = in_item.rx_byte;

        if (pos_reg == LW'(SIZE_POS))
        begin
            if (total > TOTAL_BITS'(BUFFER_BYTES))
            begin
                oversize = 1'b1;
            end
            else
            begin
                len_eff = LW'(total);
            end
        end
        len_ext = (LW+1)'(len_eff);

        if (in_fire)
        begin
            if (in_item.action == ACT_ABORT)
            begin
                pos_next = '0;
                len_next = '0;
            end
            else if (pos_reg == '0)
            begin
                if (match)
                begin
                    len_next = LW'(HDR_TRL_BYTES);
                    pos_next = LW'(1);
                end
            end
            else if (pos_reg == LW'(1))
            begin
                if (match)
                begin
                    pos_next = LW'(ID_POS);
                end
                else
                begin
                    pos_next = '0;
                    len_next = '0;
                end
            end
            else if (oversize)
            begin
                pos_next = '0;
                len_next = '0;
            end
            else
            begin
                // accumulate id, size and payload; hold the checksum high byte
                if (pos_reg == LW'(ID_POS))
                begin
                    sum_next = 16'(in_item.rx_byte);
                end
                else if (pos_ext + (LW+1)'(3) <= len_ext)
                begin
                    sum_next = sum_reg + 16'(in_item.rx_byte);
                end
                if (pos_ext + (LW+1)'(2) == len_ext)
                begin
                    hi_next = in_item.rx_byte;
                end

                if (pos_ext + (LW+1)'(1) < len_ext)
                begin
                    cmd_valid = 1'b1;
                    pos_next  = pos_reg + LW'(1);
                    len_next  = len_eff;
                end
                else
                begin
                    pos_next = '0;
                    len_next = '0;
                    if (sum_reg == {hi_reg, in_item.rx_byte})
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = CMD_LAST;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/pds_fifo.sv =====
`timescale 1ns / 1ps
module pds_fifo
    import pds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_fire;
        rd_ptr_next = rd_ptr_reg ^ pop_fire;
        count_next  = count_reg + 2'(push_fire) - 2'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/pds_replay.sv =====
`timescale 1ns / 1ps
`include "packet_deframer_sum16_assert.svh"
module pds_replay
    import pds_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    rdata_reg;
    replay_state_t state_reg, state_next;
    logic [AW-1:0] rd_pos_reg, rd_pos_next;
    logic [AW-1:0] last_pos_reg, last_pos_next;
    logic          cmd_fire;
    logic          out_fire;
    logic          at_last;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign out_fire = out_valid && out_ready;
    assign at_last  = (rd_pos_reg == last_pos_reg);

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            mem[cmd.addr[AW-1:0]] <= cmd.data;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= mem[rd_pos_reg];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rd_pos_next   = rd_pos_reg;
        last_pos_next = last_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.kind == CMD_LAST)
                begin
                    state_next    = ST_READ;
                    rd_pos_next   = AW'(ID_POS);
                    last_pos_next = cmd.addr[AW-1:0];
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next  = ST_READ;
                        rd_pos_next = rd_pos_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready         = 1'b0;
        out_valid         = 1'b0;
        out_item.out_byte = rdata_reg;
        out_item.last     = at_last;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_READ:
            begin
                out_valid = 1'b0;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_pos_reg   <= '0;
            last_pos_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_pos_reg   <= rd_pos_next;
            last_pos_reg <= last_pos_next;
        end
    end

    `PDS_ASSERT(a_write_only_idle, !cmd_fire || state_reg == ST_IDLE)
    `PDS_ASSERT(a_pos_in_run, state_reg == ST_IDLE || (rd_pos_reg >= AW'(ID_POS) && rd_pos_reg <= last_pos_reg))
    `PDS_ASSERT_NEXT(a_last_ends_run, out_fire && out_item.last, state_reg == ST_IDLE)
    `PDS_ASSERT_NEXT(a_start_reads, cmd_fire && cmd.kind == CMD_LAST, state_reg == ST_READ && rd_pos_reg == AW'(ID_POS))

endmodule
